@@ src/nms_pkg.sv @@
`default_nettype none
package nms_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam cnt_t MAX_CNT = cnt_t'(MAX_ELEMENTS);

  // Write and read request for one single-port-read memory.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic start;
    cnt_t n;
  } eng_cmd_t;

endpackage
`default_nettype wire

@@ src/nms_ram.sv @@
`default_nettype none
module nms_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/nms_engine.sv @@
`default_nettype none
module nms_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire nms_pkg::eng_cmd_t cmd,
  output logic                   done,
  output nms_pkg::mem_req_t      main_req,
  input  wire nms_pkg::data_t    main_rdata,
  output nms_pkg::mem_req_t      side_req,
  input  wire nms_pkg::data_t    side_rdata
);

  typedef enum logic [2:0] {
    E_IDLE, E_SPA, E_SPB, E_MSTART, E_MHG, E_MHH, E_MSEL, E_MFETCH
  } state_t;

  state_t state;
  nms_pkg::cnt_t n, k, kd, gn, hn, out, gp, hp;
  nms_pkg::data_t prev, g_head, h_head;
  logic dv, to_first, split, g_ok, h_ok, sel_g;

  nms_pkg::cnt_t hend, gp_inc, hp_inc;
  logic brk, tf, take_g, split_wr;

  always_comb begin
    hend = nms_pkg::cnt_t'(gn + hn);
    gp_inc = nms_pkg::cnt_t'(gp + 1'b1);
    hp_inc = nms_pkg::cnt_t'(hp + 1'b1);
    // A descending step starts a new run, which goes to the other region.
    brk = dv && (kd != '0) && (main_rdata < prev);
    tf = brk ? !to_first : to_first;
    split_wr = dv && (((state == E_SPA) && tf) || ((state == E_SPB) && !tf));
    // Ties go to the first region.
    take_g = g_ok && (!h_ok || !(h_head < g_head));

    main_req.raddr = k[nms_pkg::ADDR_W-1:0];
    main_req.we = (state == E_MSEL) && (g_ok || h_ok);
    main_req.waddr = out[nms_pkg::ADDR_W-1:0];
    main_req.wdata = take_g ? g_head : h_head;

    side_req.we = split_wr;
    side_req.waddr = (state == E_SPA) ? gn[nms_pkg::ADDR_W-1:0] : hend[nms_pkg::ADDR_W-1:0];
    side_req.wdata = main_rdata;
    case (state)
      E_MSTART: side_req.raddr = gp[nms_pkg::ADDR_W-1:0];
      E_MHG:    side_req.raddr = hp[nms_pkg::ADDR_W-1:0];
      E_MSEL:   side_req.raddr = take_g ? gp_inc[nms_pkg::ADDR_W-1:0]
                                        : hp_inc[nms_pkg::ADDR_W-1:0];
      default:  side_req.raddr = gp[nms_pkg::ADDR_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done <= 1'b0;
    end else begin
      case (state)
        E_IDLE: begin
          done <= 1'b0;
          if (cmd.start) begin
            n <= cmd.n;
            k <= '0;
            dv <= 1'b0;
            to_first <= 1'b1;
            split <= 1'b0;
            gn <= '0;
            state <= E_SPA;
          end
        end
        E_SPA, E_SPB: begin
          if (k < n) begin
            k <= nms_pkg::cnt_t'(k + 1'b1);
            kd <= k;
            dv <= 1'b1;
          end else begin
            dv <= 1'b0;
          end
          if (dv) begin
            to_first <= tf;
            prev <= main_rdata;
            if (brk) begin
              split <= 1'b1;
            end
            if (split_wr && (state == E_SPA)) begin
              gn <= nms_pkg::cnt_t'(gn + 1'b1);
            end
            if (split_wr && (state == E_SPB)) begin
              hn <= nms_pkg::cnt_t'(hn + 1'b1);
            end
          end
          if ((k == n) && !dv) begin
            if (state == E_SPA) begin
              if (!split) begin
                done <= 1'b1;
                state <= E_IDLE;
              end else begin
                k <= '0;
                to_first <= 1'b1;
                hn <= '0;
                state <= E_SPB;
              end
            end else begin
              out <= '0;
              gp <= '0;
              hp <= gn;
              state <= E_MSTART;
            end
          end
        end
        E_MSTART: begin
          if (out == n) begin
            k <= '0;
            dv <= 1'b0;
            to_first <= 1'b1;
            split <= 1'b0;
            gn <= '0;
            state <= E_SPA;
          end else begin
            g_ok <= (gp < gn);
            h_ok <= (hp < hend);
            state <= E_MHG;
          end
        end
        E_MHG: begin
          g_head <= side_rdata;
          state <= E_MHH;
        end
        E_MHH: begin
          h_head <= side_rdata;
          state <= E_MSEL;
        end
        E_MSEL: begin
          if (!g_ok && !h_ok) begin
            state <= E_MSTART;
          end else begin
            out <= nms_pkg::cnt_t'(out + 1'b1);
            sel_g <= take_g;
            if (take_g) begin
              gp <= gp_inc;
              prev <= g_head;
            end else begin
              hp <= hp_inc;
              prev <= h_head;
            end
            state <= E_MFETCH;
          end
        end
        E_MFETCH: begin
          if (sel_g) begin
            g_head <= side_rdata;
            g_ok <= (gp < gn) && !(side_rdata < prev);
          end else begin
            h_head <= side_rdata;
            h_ok <= (hp < hend) && !(side_rdata < prev);
          end
          state <= E_MSEL;
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/natural_merge_sorter_unit.sv @@
`default_nettype none
// Channel   Direction  Handshake            Payload
// input     in         valid / stall        value, last
// result    out        res_valid / res_stall value_res, last_res, overflow
//
// Loading takes one element per cycle. Each pass first splits the runs of the main store
// alternately into two regions of the side store, then merges run pairs back;
// passes repeat until the stores hold one run, at most about log2(n) + 1 of them, and
// each store has a single read port. Emitting steps through read, capture and output
// states for each element and holds in the output state while res_stall is high.
// rst clears the control state only; the stores need no clearing.
module natural_merge_sorter_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           valid,
  output logic                stall,
  input  wire nms_pkg::data_t value,
  input  wire logic           last,
  output logic                res_valid,
  input  wire logic           res_stall,
  output nms_pkg::data_t      value_res,
  output logic                last_res,
  output logic                overflow
);

  typedef enum logic [2:0] {
    T_LOAD, T_SORT_GO, T_SORT_WAIT, T_EMIT_RD, T_EMIT_CAP, T_EMIT_OUT
  } state_t;

  state_t state;
  nms_pkg::cnt_t count, ek, cnt_nx;
  logic overflow_seen, eng_done, in_xfer;
  nms_pkg::eng_cmd_t cmd;
  nms_pkg::mem_req_t main_req, eng_main, side_req;
  nms_pkg::data_t main_rdata, side_rdata;

  always_comb begin
    stall = (state != T_LOAD);
    in_xfer = valid && !stall;
    cnt_nx = (count < nms_pkg::MAX_CNT) ? nms_pkg::cnt_t'(count + 1'b1) : count;
    cmd.start = (state == T_SORT_GO);
    cmd.n = count;

    main_req = eng_main;
    if (state == T_LOAD) begin
      main_req.we = in_xfer && (count < nms_pkg::MAX_CNT);
      main_req.waddr = count[nms_pkg::ADDR_W-1:0];
      main_req.wdata = value;
    end else if (state == T_EMIT_RD) begin
      main_req.we = 1'b0;
      main_req.raddr = ek[nms_pkg::ADDR_W-1:0];
    end
  end

  nms_ram #(.DEPTH(nms_pkg::MAX_ELEMENTS), .WIDTH(nms_pkg::DATA_W)) u_main (
    .clk   (clk),
    .we    (main_req.we),
    .waddr (main_req.waddr),
    .wdata (main_req.wdata),
    .raddr (main_req.raddr),
    .rdata (main_rdata)
  );

  nms_ram #(.DEPTH(nms_pkg::MAX_ELEMENTS), .WIDTH(nms_pkg::DATA_W)) u_side (
    .clk   (clk),
    .we    (side_req.we),
    .waddr (side_req.waddr),
    .wdata (side_req.wdata),
    .raddr (side_req.raddr),
    .rdata (side_rdata)
  );

  nms_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .done       (eng_done),
    .main_req   (eng_main),
    .main_rdata (main_rdata),
    .side_req   (side_req),
    .side_rdata (side_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_LOAD;
      count <= '0;
      overflow_seen <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        T_LOAD: begin
          if (in_xfer) begin
            count <= cnt_nx;
            if (count == nms_pkg::MAX_CNT) begin
              overflow_seen <= 1'b1;
            end
            // A batch of one element is already sorted.
            if (last) begin
              ek <= '0;
              state <= (cnt_nx == nms_pkg::cnt_t'(1)) ? T_EMIT_RD : T_SORT_GO;
            end
          end
        end
        T_SORT_GO: begin
          state <= T_SORT_WAIT;
        end
        T_SORT_WAIT: begin
          if (eng_done) begin
            ek <= '0;
            state <= T_EMIT_RD;
          end
        end
        T_EMIT_RD: begin
          state <= T_EMIT_CAP;
        end
        T_EMIT_CAP: begin
          value_res <= main_rdata;
          last_res <= (nms_pkg::cnt_t'(ek + 1'b1) == count);
          overflow <= overflow_seen;
          res_valid <= 1'b1;
          state <= T_EMIT_OUT;
        end
        T_EMIT_OUT: begin
          if (!res_stall) begin
            res_valid <= 1'b0;
            if (last_res) begin
              count <= '0;
              overflow_seen <= 1'b0;
              state <= T_LOAD;
            end else begin
              ek <= nms_pkg::cnt_t'(ek + 1'b1);
              state <= T_EMIT_RD;
            end
          end
        end
        default: begin
          state <= T_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ bench/tb_natural_merge_sorter_unit.sv @@
module tb_natural_merge_sorter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES = 500;

  typedef struct {
    nms_pkg::data_t value;
    logic           last;
    logic           dropped;
  } sorted_item_t;

  typedef struct {
    nms_pkg::data_t value;
    logic           last;
    logic           typed;
    nms_pkg::data_t sorted;
  } stim_row_t;

  typedef enum int {
    STYLE_RANDOM,
    STYLE_TIES,
    STYLE_RISING,
    STYLE_FALLING,
    STYLE_BROKEN,
    STYLE_EXTREME
  } value_style_e;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           valid = 1'b0;
  logic           last = 1'b0;
  logic           res_stall = 1'b0;
  nms_pkg::data_t value = '0;
  logic           stall;
  logic           res_valid;
  nms_pkg::data_t value_res;
  logic           last_res;
  logic           overflow;

  sorted_item_t   sorted_due[$];
  nms_pkg::data_t batch_buf[$];
  logic           batch_dropped = 1'b0;
  stim_row_t      directed_rows[23];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int batches_closed = 0;
  int overflow_batches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  natural_merge_sorter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .valid     (valid),
    .stall     (stall),
    .value     (value),
    .last      (last),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .value_res (value_res),
    .last_res  (last_res),
    .overflow  (overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Appends one expected result to the tail of the result queue.
  function automatic void add_due(nms_pkg::data_t v, logic is_last, logic dropped);
    sorted_item_t item;
    item.value = v;
    item.last = is_last;
    item.dropped = dropped;
    sorted_due.insert(sorted_due.size(), item);
  endfunction

  // One natural merge pass over batch_buf. Runs go alternately to the first and
  // second half of a side buffer, then run pairs are merged back, first half wins
  // ties. Returns 0 when the batch is already a single ascending run.
  function automatic bit merge_round();
    nms_pkg::data_t side[$];
    int    n_first, n_all, gp, hp, ge, he, k;
    bit    to_first, split;
    to_first = 1'b1;
    split = 1'b0;
    for (k = 0; k < batch_buf.size(); k++) begin
      if (k > 0 && batch_buf[k] < batch_buf[k-1]) begin
        to_first = !to_first;
        split = 1'b1;
      end
      if (to_first) side.insert(side.size(), batch_buf[k]);
    end
    if (!split) return 1'b0;
    n_first = side.size();
    to_first = 1'b1;
    for (k = 0; k < batch_buf.size(); k++) begin
      if (k > 0 && batch_buf[k] < batch_buf[k-1]) to_first = !to_first;
      if (!to_first) side.insert(side.size(), batch_buf[k]);
    end
    n_all = side.size();
    batch_buf.delete();
    gp = 0;
    hp = n_first;
    while (gp < n_first || hp < n_all) begin
      ge = gp;
      if (ge < n_first) begin
        ge++;
        while (ge < n_first && !(side[ge] < side[ge-1])) ge++;
      end
      he = hp;
      if (he < n_all) begin
        he++;
        while (he < n_all && !(side[he] < side[he-1])) he++;
      end
      while (gp < ge && hp < he) begin
        if (!(side[hp] < side[gp])) begin
          batch_buf.insert(batch_buf.size(), side[gp]);
          gp++;
        end else begin
          batch_buf.insert(batch_buf.size(), side[hp]);
          hp++;
        end
      end
      while (gp < ge) begin
        batch_buf.insert(batch_buf.size(), side[gp]);
        gp++;
      end
      while (hp < he) begin
        batch_buf.insert(batch_buf.size(), side[hp]);
        hp++;
      end
    end
    return 1'b1;
  endfunction

  // Stores one accepted value unless the batch is full; a closing value sorts the batch and queues its results.
  function automatic void absorb_value(nms_pkg::data_t v, logic closes);
    int k;
    if (batch_buf.size() < nms_pkg::MAX_ELEMENTS) batch_buf.insert(batch_buf.size(), v);
    else batch_dropped = 1'b1;
    if (closes) begin
      while (batch_buf.size() > 1) begin
        if (!merge_round()) break;
      end
      for (k = 0; k < batch_buf.size(); k++)
        add_due(batch_buf[k], k == batch_buf.size() - 1, batch_dropped);
      if (batch_dropped) overflow_batches++;
      batches_closed++;
      batch_buf.delete();
      batch_dropped = 1'b0;
    end
  endfunction

  task automatic send_item(nms_pkg::data_t v, logic closes, logic typed,
                           nms_pkg::data_t typed_val);
    while ($urandom_range(99) < send_idle_pct) begin
      valid <= 1'b0;
      @(negedge clk);
    end
    valid <= 1'b1;
    value <= v;
    last <= closes;
    @(posedge clk);
    while (stall) @(posedge clk);
    items_sent++;
    if (typed) begin
      add_due(typed_val, 1'b1, 1'b0);
      batches_closed++;
    end else begin
      absorb_value(v, closes);
    end
    @(negedge clk);
  endtask

  task automatic send_batch(int size);
    value_style_e   style;
    nms_pkg::data_t base, v;
    nms_pkg::data_t extremes[4];
    int             i;
    extremes = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1};
    style = value_style_e'($urandom_range(5));
    base = nms_pkg::data_t'($urandom_range(2000)) - 1000;
    for (i = 0; i < size; i++) begin
      case (style)
        STYLE_TIES:    v = nms_pkg::data_t'($urandom_range(6)) - 3;
        STYLE_RISING:  v = base + nms_pkg::data_t'(i * 3);
        STYLE_FALLING: v = base - nms_pkg::data_t'(i * 3);
        STYLE_BROKEN:  v = ($urandom_range(7) == 0) ? nms_pkg::data_t'($urandom)
                                                    : base + nms_pkg::data_t'(i);
        STYLE_EXTREME: v = extremes[$urandom_range(3)];
        default:       v = nms_pkg::data_t'($urandom);
      endcase
      send_item(v, i == size - 1, 1'b0, '0);
    end
  endtask

  // Stops offering and waits until the block has handed back everything it owes.
  task automatic drain_results();
    valid <= 1'b0;
    while (sorted_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    sorted_item_t want;
    if (res_valid && !res_stall) begin
      results_seen++;
      if (sorted_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value %0d last %0b overflow %0b",
                 $time, value_res, last_res, overflow);
      end else begin
        want = sorted_due.pop_front();
        if (value_res !== want.value || last_res !== want.last ||
            overflow !== want.dropped) begin
          errors++;
          $display("%0t: expected value %0d last %0b overflow %0b, got %0d %0b %0b",
                   $time, want.value, want.last, want.dropped,
                   value_res, last_res, overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (valid && !stall) || (res_valid && !res_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int r, sz, phase;
    directed_rows = '{
      // Single-value batches come back unchanged and alone, then a two-value batch of extremes.
      '{32'sd0,        1'b1, 1'b1, 32'sd0},
      '{32'sh7fffffff, 1'b1, 1'b1, 32'sh7fffffff},
      '{32'sh80000000, 1'b1, 1'b1, 32'sh80000000},
      '{-32'sd1,       1'b1, 1'b1, -32'sd1},
      '{32'sh7fffffff, 1'b0, 1'b0, 32'sd0},
      '{32'sh80000000, 1'b1, 1'b0, 32'sd0},
      // Ties, several short runs and a repeated value.
      '{32'sd3,        1'b0, 1'b0, 32'sd0},
      '{32'sd1,        1'b0, 1'b0, 32'sd0},
      '{32'sd2,        1'b0, 1'b0, 32'sd0},
      '{32'sd1,        1'b0, 1'b0, 32'sd0},
      '{-32'sd5,       1'b0, 1'b0, 32'sd0},
      '{32'sd7,        1'b0, 1'b0, 32'sd0},
      '{32'sd7,        1'b0, 1'b0, 32'sd0},
      '{32'sd0,        1'b1, 1'b0, 32'sd0},
      // Strictly descending, so every value is a run of its own.
      '{32'sd4,        1'b0, 1'b0, 32'sd0},
      '{32'sd3,        1'b0, 1'b0, 32'sd0},
      '{32'sd2,        1'b0, 1'b0, 32'sd0},
      '{32'sd1,        1'b0, 1'b0, 32'sd0},
      '{-32'sd1,       1'b1, 1'b0, 32'sd0},
      // Already sorted: no merge pass is needed.
      '{-32'sd2,       1'b0, 1'b0, 32'sd0},
      '{32'sd0,        1'b0, 1'b0, 32'sd0},
      '{32'sd0,        1'b0, 1'b0, 32'sd0},
      '{32'sd9,        1'b1, 1'b0, 32'sd0}
    };
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (directed_rows[i])
          send_item(directed_rows[i].value, directed_rows[i].last,
                    directed_rows[i].typed, directed_rows[i].sorted);
        // Hold results back while more batches are offered so the input backs up.
        hold_left = HOLD_CYCLES;
        repeat (3) send_batch(10);
        send_batch(nms_pkg::MAX_ELEMENTS);
        send_batch(nms_pkg::MAX_ELEMENTS + 1);
      end
      if (phase == 2) send_batch(nms_pkg::MAX_ELEMENTS + 6);
      while (items_sent < 150 * (phase + 1)) begin
        r = $urandom_range(99);
        if (r < 60) sz = $urandom_range(8, 1);
        else if (r < 92) sz = $urandom_range(32, 9);
        else sz = $urandom_range(nms_pkg::MAX_ELEMENTS + 6, 33);
        send_batch(sz);
      end
      drain_results();
    end
    errors += sorted_due.size();
    $display("Checked %0d sorted results from %0d batches (%0d over capacity), %0d inputs.",
             results_seen, batches_closed, overflow_batches, items_sent);
    $display("Covered three idle profiles, a long result hold-off and sizes up to %0d.",
             nms_pkg::MAX_ELEMENTS + 6);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
